// File: rtl/core/fgpr_pkg.sv
// Shared types and constants for the forward geometric pixel remap.
`default_nettype none

package fgpr_pkg;

  localparam int unsigned COORD_BITS_DEF     = 12;
  localparam int unsigned PIXEL_BITS_DEF     = 16;
  localparam int unsigned COEF_FRAC_BITS_DEF = 14;

  // Coefficients carry a sign and four integer bits above the fraction.
  localparam int unsigned COEF_INT_BITS = 5;
  // Offsets are Q12.8 style: sign, coordinate bits and eight fraction bits.
  localparam int unsigned OFS_FRAC_BITS = 8;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned RST_IMG_SIZE  = 512;

  typedef enum logic [2:0] {
    MODE_SCALE      = 3'd0,
    MODE_TRANSLATE  = 3'd1,
    MODE_ROTATE     = 3'd2,
    MODE_MIRROR_COL = 3'd3,
    MODE_MIRROR_ROW = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_IMG_WIDTH  = 3'd1,
    REG_IMG_HEIGHT = 3'd2,
    REG_COEF_A     = 3'd3,
    REG_COEF_B     = 3'd4,
    REG_OFFSET_X   = 3'd5,
    REG_OFFSET_Y   = 3'd6
  } reg_idx_e;

endpackage

`default_nettype wire

// File: rtl/core/fgpr_finish.sv
// Final mapping stage: destination coordinates, bounds test and frame size.
`default_nettype none

module fgpr_finish #(
  parameter int unsigned COORD_BITS     = fgpr_pkg::COORD_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = fgpr_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic [2:0]                                         mode_i,
  input  wire logic [COORD_BITS:0]                                w_i,
  input  wire logic [COORD_BITS:0]                                h_i,
  input  wire logic [COORD_BITS-1:0]                              col_i,
  input  wire logic [COORD_BITS-1:0]                              row_i,
  input  wire logic signed [COORD_BITS+8:0]                       ofs_x_i,
  input  wire logic signed [COORD_BITS+8:0]                       ofs_y_i,
  input  wire logic signed [COORD_BITS+COEF_FRAC_BITS+6:0]        xa_i,
  input  wire logic signed [COORD_BITS+COEF_FRAC_BITS+6:0]        yb_i,
  input  wire logic signed [COORD_BITS+COEF_FRAC_BITS+6:0]        xb_i,
  input  wire logic signed [COORD_BITS+COEF_FRAC_BITS+6:0]        ya_i,
  input  wire logic signed [COORD_BITS+COEF_FRAC_BITS+6:0]        wa_i,
  input  wire logic signed [COORD_BITS+COEF_FRAC_BITS+6:0]        hb_i,
  output logic                                                    ok_o,
  output logic [COORD_BITS-1:0]                                   dest_col_o,
  output logic [COORD_BITS-1:0]                                   dest_row_o,
  output logic [COORD_BITS:0]                                     frame_w_o,
  output logic [COORD_BITS:0]                                     frame_h_o
);

  localparam int unsigned SW  = COORD_BITS + 1;
  localparam int unsigned CW  = COEF_FRAC_BITS + fgpr_pkg::COEF_INT_BITS;
  localparam int unsigned DW  = COORD_BITS + 2;
  localparam int unsigned PW  = DW + CW;
  localparam int unsigned FPW = SW + 1 + CW;
  localparam int unsigned RW  = PW + 2;
  localparam int unsigned OFR = fgpr_pkg::OFS_FRAC_BITS;

  localparam logic [SW-1:0]         MAX_SIZE  = SW'(1) << COORD_BITS;
  localparam logic signed [RW-1:0]  ONE_S     = RW'(1);
  localparam logic signed [RW-1:0]  COEF_BIAS = RW'((1 << COEF_FRAC_BITS) - 1);
  localparam logic signed [RW-1:0]  OFS_BIAS  = RW'((1 << OFR) - 1);
  localparam logic signed [FPW:0]   HALF      = (FPW+1)'(1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [FPW:0]   MAX_WIDE  = $signed((FPW+1)'(MAX_SIZE));

  function automatic logic signed [RW-1:0] trunc_coef(input logic signed [RW-1:0] v);
    return v[RW-1] ? ((v + COEF_BIAS) >>> COEF_FRAC_BITS) : (v >>> COEF_FRAC_BITS);
  endfunction

  function automatic logic signed [RW-1:0] trunc_ofs(input logic signed [RW-1:0] v);
    return v[RW-1] ? ((v + OFS_BIAS) >>> OFR) : (v >>> OFR);
  endfunction

  function automatic logic [SW-1:0] scaled_size(input logic signed [FPW-1:0] p);
    logic signed [FPW:0] rnd;
    rnd = ((FPW+1)'(p) + HALF) >>> COEF_FRAC_BITS;
    if (p[FPW-1]) begin
      return '0;
    end else if (rnd > MAX_WIDE) begin
      return MAX_SIZE;
    end else begin
      return rnd[SW-1:0];
    end
  endfunction

  logic signed [RW-1:0] w_s, h_s, cx_s, cy_s, col_s, row_s;
  logic signed [RW-1:0] tx, ty;
  logic signed [RW-1:0] x, y, bw_s, bh_s;
  logic [SW-1:0]        bw_scale, bh_scale;
  logic                 src_in, mode_ok, in_bounds;

  assign w_s   = $signed(RW'(w_i));
  assign h_s   = $signed(RW'(h_i));
  assign cx_s  = $signed(RW'(w_i >> 1));
  assign cy_s  = $signed(RW'(h_i >> 1));
  assign col_s = $signed(RW'(col_i));
  assign row_s = $signed(RW'(row_i));

  assign tx = trunc_ofs($signed(RW'({col_i, {OFR{1'b0}}})) + RW'(ofs_x_i));
  assign ty = trunc_ofs($signed(RW'({row_i, {OFR{1'b0}}})) + RW'(ofs_y_i));

  assign bw_scale = scaled_size(FPW'(wa_i));
  assign bh_scale = scaled_size(FPW'(hb_i));

  assign src_in = ($signed(RW'(col_i)) < w_s) && ($signed(RW'(row_i)) < h_s);

  always_comb begin
    x         = '0;
    y         = '0;
    bw_s      = w_s;
    bh_s      = h_s;
    mode_ok   = 1'b1;
    frame_w_o = w_i;
    frame_h_o = h_i;
    unique case (mode_i)
      fgpr_pkg::MODE_SCALE: begin
        x         = trunc_coef(RW'(xa_i));
        y         = trunc_coef(RW'(yb_i));
        bw_s      = $signed(RW'(bw_scale));
        bh_s      = $signed(RW'(bh_scale));
        frame_w_o = (bw_scale == '0) ? SW'(1) : bw_scale;
        frame_h_o = (bh_scale == '0) ? SW'(1) : bh_scale;
      end
      fgpr_pkg::MODE_TRANSLATE: begin
        x = (tx >= w_s) ? (tx - w_s) : (tx[RW-1] ? (tx + w_s) : tx);
        y = (ty >= h_s) ? (ty - h_s) : (ty[RW-1] ? (ty + h_s) : ty);
      end
      fgpr_pkg::MODE_ROTATE: begin
        x = trunc_coef(RW'(xa_i) - RW'(yb_i)) + cx_s;
        y = trunc_coef(RW'(xb_i) + RW'(ya_i)) + cy_s;
      end
      fgpr_pkg::MODE_MIRROR_COL: begin
        x = w_s - ONE_S - col_s;
        y = row_s;
      end
      fgpr_pkg::MODE_MIRROR_ROW: begin
        x = col_s;
        y = h_s - ONE_S - row_s;
      end
      default: begin
        mode_ok = 1'b0;
      end
    endcase
  end

  assign in_bounds = !x[RW-1] && (x < bw_s) && !y[RW-1] && (y < bh_s);
  assign ok_o      = src_in && mode_ok && in_bounds;

  assign dest_col_o = ok_o ? x[COORD_BITS-1:0] : '0;
  assign dest_row_o = ok_o ? y[COORD_BITS-1:0] : '0;

endmodule

`default_nettype wire

// File: rtl/core/forward_geometric_pixel_remap.sv
// Top level of the forward geometric pixel remap with its configuration registers.
`default_nettype none

// Usage:
// A source pixel request is taken at a rising clock edge with start high and
// busy low. The block never raises busy, so one request can enter every cycle.
// Each request yields exactly one result: done_o is high for one cycle with the
// destination column and row, the unchanged pixel, the write flag and the
// output frame size. When write_valid_o is low the pixel falls outside the
// output frame and the destination fields are zero.
// A request taken at a clock edge passes through one input register, one
// register after the multipliers, and the result register before its result
// shows. Throughput is one request per cycle.
// The receiver cannot stall; each result is valid for exactly one cycle.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i; the user must write them only while no request is in flight,
// which the block does not enforce. Reset clears all pending requests and loads
// the register defaults: scale mode, 512 x 512 image, unit factors and zero offsets.
module forward_geometric_pixel_remap #(
  parameter int unsigned COORD_BITS     = fgpr_pkg::COORD_BITS_DEF,
  parameter int unsigned PIXEL_BITS     = fgpr_pkg::PIXEL_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = fgpr_pkg::COEF_FRAC_BITS_DEF,
  localparam int unsigned CW    = COEF_FRAC_BITS + fgpr_pkg::COEF_INT_BITS,
  localparam int unsigned OW    = COORD_BITS + fgpr_pkg::OFS_FRAC_BITS + 1,
  localparam int unsigned CFG_W = (CW > OW) ? CW : OW
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [COORD_BITS-1:0]              src_col_i,
  input  wire logic [COORD_BITS-1:0]              src_row_i,
  input  wire logic [PIXEL_BITS-1:0]              pixel_value_i,
  output logic                                    done_o,
  output logic [COORD_BITS-1:0]                   dest_col_o,
  output logic [COORD_BITS-1:0]                   dest_row_o,
  output logic [PIXEL_BITS-1:0]                   out_pixel_o,
  output logic                                    write_valid_o,
  output logic [COORD_BITS:0]                     frame_width_o,
  output logic [COORD_BITS:0]                     frame_height_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [fgpr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]                   cfg_wdata_i
);

  localparam int unsigned SW  = COORD_BITS + 1;
  localparam int unsigned DW  = COORD_BITS + 2;
  localparam int unsigned PW  = DW + CW;
  localparam int unsigned FPW = SW + 1 + CW;

  localparam logic [SW-1:0] MAX_SIZE = SW'(1) << COORD_BITS;
  localparam logic [SW-1:0] RST_SIZE =
      (fgpr_pkg::RST_IMG_SIZE < (1 << COORD_BITS)) ? SW'(fgpr_pkg::RST_IMG_SIZE) : MAX_SIZE;
  localparam logic signed [CW-1:0] COEF_ONE = CW'(1) << COEF_FRAC_BITS;

  // Configuration registers.
  logic [2:0]            mode_q;
  logic [SW-1:0]         img_w_q, img_h_q;
  logic signed [CW-1:0]  coef_a_q, coef_b_q;
  logic signed [OW-1:0]  ofs_x_q, ofs_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= fgpr_pkg::MODE_SCALE;
      img_w_q  <= RST_SIZE;
      img_h_q  <= RST_SIZE;
      coef_a_q <= COEF_ONE;
      coef_b_q <= COEF_ONE;
      ofs_x_q  <= '0;
      ofs_y_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fgpr_pkg::REG_MODE:       mode_q   <= cfg_wdata_i[2:0];
        fgpr_pkg::REG_IMG_WIDTH:  img_w_q  <= cfg_wdata_i[SW-1:0];
        fgpr_pkg::REG_IMG_HEIGHT: img_h_q  <= cfg_wdata_i[SW-1:0];
        fgpr_pkg::REG_COEF_A:     coef_a_q <= $signed(cfg_wdata_i[CW-1:0]);
        fgpr_pkg::REG_COEF_B:     coef_b_q <= $signed(cfg_wdata_i[CW-1:0]);
        fgpr_pkg::REG_OFFSET_X:   ofs_x_q  <= $signed(cfg_wdata_i[OW-1:0]);
        fgpr_pkg::REG_OFFSET_Y:   ofs_y_q  <= $signed(cfg_wdata_i[OW-1:0]);
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input register.
  logic                  a_vld_q;
  logic [COORD_BITS-1:0] a_col_q, a_row_q;
  logic [PIXEL_BITS-1:0] a_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      a_col_q <= src_col_i;
      a_row_q <= src_row_i;
      a_pix_q <= pixel_value_i;
    end
  end

  // Multiplier stage.
  logic [SW-1:0]         w_eff, h_eff;
  logic [COORD_BITS-1:0] cx, cy;
  logic signed [DW-1:0]  ux, uy;
  logic signed [PW-1:0]  xa_d, yb_d, xb_d, ya_d;
  logic signed [FPW-1:0] wa_d, hb_d;
  logic                  scale_mode;

  assign w_eff = (img_w_q == '0) ? SW'(1) : ((img_w_q > MAX_SIZE) ? MAX_SIZE : img_w_q);
  assign h_eff = (img_h_q == '0) ? SW'(1) : ((img_h_q > MAX_SIZE) ? MAX_SIZE : img_h_q);
  assign cx    = w_eff[SW-1:1];
  assign cy    = h_eff[SW-1:1];

  assign scale_mode = (mode_q == fgpr_pkg::MODE_SCALE);
  assign ux = scale_mode ? $signed({2'b00, a_col_q})
                         : ($signed({2'b00, a_col_q}) - $signed({2'b00, cx}));
  assign uy = scale_mode ? $signed({2'b00, a_row_q})
                         : ($signed({2'b00, a_row_q}) - $signed({2'b00, cy}));

  assign xa_d = PW'(ux) * PW'(coef_a_q);
  assign yb_d = PW'(uy) * PW'(coef_b_q);
  assign xb_d = PW'(ux) * PW'(coef_b_q);
  assign ya_d = PW'(uy) * PW'(coef_a_q);
  assign wa_d = FPW'($signed({1'b0, w_eff})) * FPW'(coef_a_q);
  assign hb_d = FPW'($signed({1'b0, h_eff})) * FPW'(coef_b_q);

  logic                  b_vld_q;
  logic [COORD_BITS-1:0] b_col_q, b_row_q;
  logic [PIXEL_BITS-1:0] b_pix_q;
  logic [SW-1:0]         b_w_q, b_h_q;
  logic signed [PW-1:0]  b_xa_q, b_yb_q, b_xb_q, b_ya_q;
  logic signed [FPW-1:0] b_wa_q, b_hb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_col_q <= a_col_q;
      b_row_q <= a_row_q;
      b_pix_q <= a_pix_q;
      b_w_q   <= w_eff;
      b_h_q   <= h_eff;
      b_xa_q  <= xa_d;
      b_yb_q  <= yb_d;
      b_xb_q  <= xb_d;
      b_ya_q  <= ya_d;
      b_wa_q  <= wa_d;
      b_hb_q  <= hb_d;
    end
  end

  // Final stage and result register.
  logic                  ok_d;
  logic [COORD_BITS-1:0] dcol_d, drow_d;
  logic [SW-1:0]         fw_d, fh_d;

  fgpr_finish #(
    .COORD_BITS     (COORD_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_finish (
    .mode_i     (mode_q),
    .w_i        (b_w_q),
    .h_i        (b_h_q),
    .col_i      (b_col_q),
    .row_i      (b_row_q),
    .ofs_x_i    (ofs_x_q),
    .ofs_y_i    (ofs_y_q),
    .xa_i       (PW'(b_xa_q)),
    .yb_i       (PW'(b_yb_q)),
    .xb_i       (PW'(b_xb_q)),
    .ya_i       (PW'(b_ya_q)),
    .wa_i       (PW'(b_wa_q)),
    .hb_i       (PW'(b_hb_q)),
    .ok_o       (ok_d),
    .dest_col_o (dcol_d),
    .dest_row_o (drow_d),
    .frame_w_o  (fw_d),
    .frame_h_o  (fh_d)
  );

  logic                  done_q;
  logic [COORD_BITS-1:0] dcol_q, drow_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic                  ok_q;
  logic [SW-1:0]         fw_q, fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      dcol_q <= dcol_d;
      drow_q <= drow_d;
      pix_q  <= b_pix_q;
      ok_q   <= ok_d;
      fw_q   <= fw_d;
      fh_q   <= fh_d;
    end
  end

  assign done_o         = done_q;
  assign dest_col_o     = dcol_q;
  assign dest_row_o     = drow_q;
  assign out_pixel_o    = pix_q;
  assign write_valid_o  = ok_q;
  assign frame_width_o  = fw_q;
  assign frame_height_o = fh_q;

`ifndef SYNTHESIS
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##3 done_o)
    else $error("Result strobe did not follow the request after three edges.");

  a_drop_zero_dest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !write_valid_o) |-> (dest_col_o == '0 && dest_row_o == '0))
    else $error("Dropped pixel carries a nonzero destination.");

  a_write_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && write_valid_o) |->
      ({1'b0, dest_col_o} < frame_width_o && {1'b0, dest_row_o} < frame_height_o))
    else $error("Written pixel lies outside the reported frame.");
`endif

endmodule

`default_nettype wire

// File: sim/tb.sv
// Testbench for the forward geometric pixel remap: a directed table, then random requests.
module tb;
  import fgpr_pkg::*;

  localparam int unsigned CW = COEF_FRAC_BITS_DEF + COEF_INT_BITS;
  localparam int unsigned OW = COORD_BITS_DEF + OFS_FRAC_BITS + 1;
  localparam int unsigned DW = (CW > OW) ? CW : OW;
  localparam longint COEF_ONE = longint'(1) << COEF_FRAC_BITS_DEF;
  localparam longint OFS_ONE = longint'(1) << OFS_FRAC_BITS;
  localparam longint MAX_SIZE = longint'(1) << COORD_BITS_DEF;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int ITEM_TARGET = 1700;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [11:0] dest_col;
    logic [11:0] dest_row;
    logic [15:0] pixel;
    logic        wr;
    logic [12:0] fw;
    logic [12:0] fh;
  } remap_res_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DW-1:0]        data;
    logic [11:0]          col;
    logic [11:0]          row;
    logic [15:0]          pix;
    bit                   typed;
    remap_res_t           res;
  } plan_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [11:0]          src_col_i = '0;
  logic [11:0]          src_row_i = '0;
  logic [15:0]          pixel_value_i = '0;
  logic                 done_o;
  logic [11:0]          dest_col_o;
  logic [11:0]          dest_row_o;
  logic [15:0]          out_pixel_o;
  logic                 write_valid_o;
  logic [12:0]          frame_width_o;
  logic [12:0]          frame_height_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DW-1:0]        cfg_wdata_i = '0;

  // Copy of the configuration registers as the block should hold them.
  logic [2:0]    mode_q = MODE_SCALE;
  logic [12:0]   img_w_q = 13'(RST_IMG_SIZE);
  logic [12:0]   img_h_q = 13'(RST_IMG_SIZE);
  logic [CW-1:0] coef_a_q = CW'(COEF_ONE);
  logic [CW-1:0] coef_b_q = CW'(COEF_ONE);
  logic [OW-1:0] offset_x_q = '0;
  logic [OW-1:0] offset_y_q = '0;

  remap_res_t remap_exp_q[$];
  plan_row_t  plan_q[$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int result_cnt = 0;
  int dropped_cnt = 0;
  int setting_cnt = 0;
  int idle_run = 0;

  forward_geometric_pixel_remap dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .src_col_i      (src_col_i),
    .src_row_i      (src_row_i),
    .pixel_value_i  (pixel_value_i),
    .done_o         (done_o),
    .dest_col_o     (dest_col_o),
    .dest_row_o     (dest_row_o),
    .out_pixel_o    (out_pixel_o),
    .write_valid_o  (write_valid_o),
    .frame_width_o  (frame_width_o),
    .frame_height_o (frame_height_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint eff_size(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIZE) return MAX_SIZE;
    return longint'(v);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint round_coef(longint p);
    if (p >= 0) return (p + COEF_ONE / 2) / COEF_ONE;
    return -((-p + COEF_ONE / 2) / COEF_ONE);
  endfunction

  function automatic longint wrap_axis(longint v, longint size);
    if (v >= size) return v - size;
    if (v < 0) return v + size;
    return v;
  endfunction

  function automatic remap_res_t predict_remap(logic [11:0] c, logic [11:0] r, logic [15:0] p);
    longint w, h, col, row, a, b, bw, bh, fw, fh, x, y, cx, cy, dx, dy;
    bit ok;
    remap_res_t res;
    w = eff_size(img_w_q);
    h = eff_size(img_h_q);
    col = longint'(c);
    row = longint'(r);
    a = longint'($signed(coef_a_q));
    b = longint'($signed(coef_b_q));
    bw = w;
    bh = h;
    fw = w;
    fh = h;
    x = 0;
    y = 0;
    ok = (col < w) && (row < h);
    case (mode_q)
      MODE_SCALE: begin
        bw = clamp(round_coef(w * a), 0, MAX_SIZE);
        bh = clamp(round_coef(h * b), 0, MAX_SIZE);
        fw = (bw < 1) ? 1 : bw;
        fh = (bh < 1) ? 1 : bh;
        x = (col * a) / COEF_ONE;
        y = (row * b) / COEF_ONE;
      end
      MODE_TRANSLATE: begin
        x = wrap_axis((col * OFS_ONE + longint'($signed(offset_x_q))) / OFS_ONE, w);
        y = wrap_axis((row * OFS_ONE + longint'($signed(offset_y_q))) / OFS_ONE, h);
      end
      MODE_ROTATE: begin
        cx = w / 2;
        cy = h / 2;
        dx = col - cx;
        dy = row - cy;
        x = (dx * a - dy * b) / COEF_ONE + cx;
        y = (dx * b + dy * a) / COEF_ONE + cy;
      end
      MODE_MIRROR_COL: begin
        x = w - 1 - col;
        y = row;
      end
      MODE_MIRROR_ROW: begin
        x = col;
        y = h - 1 - row;
      end
      default: ok = 1'b0;
    endcase
    if (x < 0 || x >= bw || y < 0 || y >= bh) ok = 1'b0;
    if (!ok) begin
      x = 0;
      y = 0;
    end
    res.dest_col = x[11:0];
    res.dest_row = y[11:0];
    res.pixel = p;
    res.wr = ok;
    res.fw = fw[12:0];
    res.fh = fh[12:0];
    return res;
  endfunction

  function automatic void plan_cfg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    plan_q.push_back(row);
  endfunction

  function automatic void plan_pix(logic [11:0] c, logic [11:0] r, logic [15:0] p,
                                   bit typed = 1'b0, remap_res_t want = '0);
    plan_row_t row;
    row = '{default: '0};
    row.col = c;
    row.row = r;
    row.pix = p;
    row.typed = typed;
    row.res = want;
    plan_q.push_back(row);
  endfunction

  function automatic void build_plan();
    plan_pix(12'd0, 12'd0, 16'h0000, 1'b1, '{12'd0, 12'd0, 16'h0000, 1'b1, 13'd512, 13'd512});
    plan_pix(12'd511, 12'd511, 16'hFFFF, 1'b1,
             '{12'd511, 12'd511, 16'hFFFF, 1'b1, 13'd512, 13'd512});
    plan_pix(12'd512, 12'd7, 16'h1234, 1'b1, '{12'd0, 12'd0, 16'h1234, 1'b0, 13'd512, 13'd512});
    plan_pix(12'd4095, 12'd4095, 16'hA5A5, 1'b1,
             '{12'd0, 12'd0, 16'hA5A5, 1'b0, 13'd512, 13'd512});
    // Oversized width acts as the maximum, a zero height as one; scaled sizes saturate.
    plan_cfg(REG_IMG_WIDTH, DW'(13'h1FFF));
    plan_cfg(REG_IMG_HEIGHT, DW'(0));
    plan_cfg(REG_COEF_A, DW'(262143));
    plan_cfg(REG_COEF_B, DW'(-262144));
    plan_pix(12'd4095, 12'd0, 16'h0F0F);
    plan_pix(12'd0, 12'd0, 16'hF0F0);
    plan_cfg(REG_IMG_WIDTH, DW'(100));
    plan_cfg(REG_IMG_HEIGHT, DW'(50));
    plan_cfg(REG_COEF_A, DW'(24576));
    plan_cfg(REG_COEF_B, DW'(8192));
    plan_pix(12'd99, 12'd49, 16'h5555);
    plan_pix(12'd100, 12'd0, 16'hAAAA);
    plan_cfg(REG_MODE, DW'(MODE_TRANSLATE));
    plan_cfg(REG_IMG_WIDTH, DW'(4096));
    plan_cfg(REG_IMG_HEIGHT, DW'(4096));
    plan_cfg(REG_OFFSET_X, DW'(-1048576));
    plan_cfg(REG_OFFSET_Y, DW'(1048575));
    plan_pix(12'd4095, 12'd0, 16'h0001);
    plan_pix(12'd0, 12'd4095, 16'h8000);
    // Fractional shifts truncate toward zero before the wrap.
    plan_cfg(REG_IMG_WIDTH, DW'(100));
    plan_cfg(REG_IMG_HEIGHT, DW'(50));
    plan_cfg(REG_OFFSET_X, DW'(-384));
    plan_cfg(REG_OFFSET_Y, DW'(640));
    plan_pix(12'd0, 12'd0, 16'h1111);
    plan_pix(12'd99, 12'd49, 16'h2222);
    plan_cfg(REG_MODE, DW'(MODE_ROTATE));
    plan_cfg(REG_IMG_WIDTH, DW'(101));
    plan_cfg(REG_IMG_HEIGHT, DW'(61));
    plan_cfg(REG_COEF_A, DW'(0));
    plan_cfg(REG_COEF_B, DW'(16384));
    plan_pix(12'd50, 12'd30, 16'h3333);
    plan_pix(12'd0, 12'd0, 16'h4444);
    plan_pix(12'd100, 12'd60, 16'h6666);
    plan_cfg(REG_COEF_A, DW'(-16384));
    plan_cfg(REG_COEF_B, DW'(0));
    plan_pix(12'd0, 12'd0, 16'h7777);
    plan_cfg(REG_MODE, DW'(MODE_MIRROR_COL));
    plan_cfg(REG_IMG_WIDTH, DW'(4096));
    plan_cfg(REG_IMG_HEIGHT, DW'(4096));
    plan_pix(12'd0, 12'd4095, 16'h9999);
    plan_pix(12'd4095, 12'd0, 16'hBBBB);
    plan_cfg(REG_MODE, DW'(MODE_MIRROR_ROW));
    plan_cfg(REG_IMG_WIDTH, DW'(0));
    plan_pix(12'd0, 12'd0, 16'hCCCC);
    plan_pix(12'd1, 12'd0, 16'hDDDD);
    // Spare mode codes drop every pixel; the spare register index changes nothing.
    plan_cfg(REG_MODE, DW'(MODE_SPARE_HI));
    plan_cfg(REG_SPARE, '1);
    plan_pix(12'd3, 12'd3, 16'hEEEE, 1'b1, '{12'd0, 12'd0, 16'hEEEE, 1'b0, 13'd1, 13'd4096});
    plan_cfg(REG_MODE, DW'(MODE_SPARE_LO));
    plan_pix(12'd0, 12'd0, 16'h0101, 1'b1, '{12'd0, 12'd0, 16'h0101, 1'b0, 13'd1, 13'd4096});
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_MODE:       mode_q = data[2:0];
      REG_IMG_WIDTH:  img_w_q = data[12:0];
      REG_IMG_HEIGHT: img_h_q = data[12:0];
      REG_COEF_A:     coef_a_q = data[CW-1:0];
      REG_COEF_B:     coef_b_q = data[CW-1:0];
      REG_OFFSET_X:   offset_x_q = data[OW-1:0];
      REG_OFFSET_Y:   offset_y_q = data[OW-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input logic [11:0] c, input logic [11:0] r, input logic [15:0] p,
                            input bit typed, input remap_res_t want);
    start <= 1'b1;
    src_col_i <= c;
    src_row_i <= r;
    pixel_value_i <= p;
    do @(posedge clk_i); while (busy !== 1'b0);
    remap_exp_q.push_back(typed ? want : predict_remap(c, r, p));
    sent_cnt++;
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    while (remap_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_setting(input bit extreme);
    logic [2:0]  m;
    logic [12:0] wv, hv;
    int sel, a, b, ox, oy, span;
    sel = $urandom_range(0, 19);
    m = (sel < 19) ? 3'(sel % 5) : 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    if (extreme) begin
      case ($urandom_range(0, 3))
        0: wv = 13'd0;
        1: wv = 13'd1;
        2: wv = 13'(MAX_SIZE);
        default: wv = 13'h1FFF;
      endcase
      case ($urandom_range(0, 3))
        0: hv = 13'd0;
        1: hv = 13'd1;
        2: hv = 13'(MAX_SIZE);
        default: hv = 13'($urandom_range(4097, 8191));
      endcase
      a = $urandom_range(0, 1) ? -262144 : 262143;
      b = $urandom_range(0, 1) ? -262144 : 262143;
      ox = $urandom_range(0, 1) ? -1048576 : 1048575;
      oy = $urandom_range(0, 1) ? -1048576 : 1048575;
    end else begin
      wv = ($urandom_range(0, 2) == 0) ? 13'($urandom_range(1, 64)) : 13'($urandom_range(1, 4096));
      hv = ($urandom_range(0, 2) == 0) ? 13'($urandom_range(1, 64)) : 13'($urandom_range(1, 4096));
      a = int'($urandom_range(0, 65536)) - 16384;
      b = int'($urandom_range(0, 65536)) - 16384;
      if (m == MODE_ROTATE) begin
        case ($urandom_range(0, 6))
          0: begin a = 16384;  b = 0;      end
          1: begin a = 0;      b = 16384;  end
          2: begin a = -16384; b = 0;      end
          3: begin a = 0;      b = -16384; end
          4: begin a = 11585;  b = 11585;  end
          5: begin a = 14189;  b = -8192;  end
          default: begin
            a = int'($urandom_range(0, 32768)) - 16384;
            b = int'($urandom_range(0, 32768)) - 16384;
          end
        endcase
      end
      span = int'(eff_size(wv)) * 256 + 1024;
      ox = int'($urandom_range(0, 2 * span)) - span;
      span = int'(eff_size(hv)) * 256 + 1024;
      oy = int'($urandom_range(0, 2 * span)) - span;
    end
    write_reg(REG_MODE, DW'(m));
    write_reg(REG_IMG_WIDTH, DW'(wv));
    write_reg(REG_IMG_HEIGHT, DW'(hv));
    write_reg(REG_COEF_A, DW'(a));
    write_reg(REG_COEF_B, DW'(b));
    write_reg(REG_OFFSET_X, DW'(ox));
    write_reg(REG_OFFSET_Y, DW'(oy));
    cfg_we_i <= 1'b0;
    setting_cnt++;
  endtask

  always @(posedge clk_i) begin : check_results
    remap_res_t got;
    remap_res_t want;
    if (rst_ni && done_o) begin
      got = {dest_col_o, dest_row_o, out_pixel_o, write_valid_o, frame_width_o, frame_height_o};
      result_cnt++;
      if (!write_valid_o) dropped_cnt++;
      if (remap_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) $display("tb: result with no request pending at %0t", $realtime);
      end else begin
        want = remap_exp_q.pop_front();
        if (got.dest_col !== want.dest_col || got.dest_row !== want.dest_row ||
            got.pixel !== want.pixel || got.wr !== want.wr ||
            got.fw !== want.fw || got.fh !== want.fh) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display({"tb: mismatch exp/got col %0d/%0d row %0d/%0d pix %h/%h wr %b/%b ",
                      "fw %0d/%0d fh %0d/%0d"},
                     want.dest_col, got.dest_col, want.dest_row, got.dest_row,
                     want.pixel, got.pixel, want.wr, got.wr,
                     want.fw, got.fw, want.fh, got.fh);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= STALL_LIMIT) begin
      $display("tb: no progress for %0d cycles", STALL_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   r;
    bit          cfg_open;
    int          seg, pct, rand_sent, directed;
    longint      w, h;
    logic [11:0] col, row;
    build_plan();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_open = 1'b0;
    foreach (plan_q[i]) begin
      r = plan_q[i];
      if (r.is_cfg) begin
        if (!cfg_open) begin
          drain_requests();
          cfg_open = 1'b1;
          setting_cnt++;
        end
        write_reg(r.idx, r.data);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_pixel(r.col, r.row, r.pix, r.typed, r.res);
      end
    end
    directed = sent_cnt;

    // Each setting is loaded only once the pipeline has emptied.
    seg = 0;
    rand_sent = 0;
    while (rand_sent < ITEM_TARGET) begin
      drain_requests();
      random_setting(seg % 6 == 5);
      w = eff_size(img_w_q);
      h = eff_size(img_h_q);
      repeat ($urandom_range(30, 110)) begin
        pct = (rand_sent < ITEM_TARGET / 3) ? 7 : ((rand_sent < 2 * ITEM_TARGET / 3) ? 52 : 0);
        col = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, int'(w) - 1))
                                            : 12'($urandom_range(0, 4095));
        row = ($urandom_range(0, 99) < 85) ? 12'($urandom_range(0, int'(h) - 1))
                                            : 12'($urandom_range(0, 4095));
        send_pixel(col, row, 16'($urandom()), 1'b0, '0);
        rand_sent++;
        while ($urandom_range(0, 99) < pct) begin
          start <= 1'b0;
          @(posedge clk_i);
        end
      end
      seg++;
    end
    drain_requests();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    err_cnt += remap_exp_q.size();

    $display("tb: %0d requests (%0d from the table), %0d results, %0d dropped, %0d mismatches",
             sent_cnt, directed, result_cnt, dropped_cnt, err_cnt);
    $display("tb: %0d register settings across all modes and spare codes, sender gaps 7/52/0 pct",
             setting_cnt);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
